### rtl/pcst_pkg.sv
package pcst_pkg;

  localparam int DepthDefault = 16;
  localparam int MaxResults   = 16;

  localparam logic [2:0] REQ_ADD_REP = 3'd0;
  localparam logic [2:0] REQ_ADD_ONE = 3'd1;
  localparam logic [2:0] REQ_CANCEL  = 3'd2;
  localparam logic [2:0] REQ_TICK    = 3'd3;
  localparam logic [2:0] REQ_RESULT  = 3'd4;
  localparam logic [2:0] REQ_WARMUP  = 3'd5;
  localparam logic [2:0] REQ_ACTIV   = 3'd6;
  localparam logic [2:0] REQ_STATUS  = 3'd7;

  localparam logic [2:0] KIND_ACK    = 3'd0;
  localparam logic [2:0] KIND_REFUSE = 3'd1;
  localparam logic [2:0] KIND_CHECK  = 3'd2;
  localparam logic [2:0] KIND_REPORT = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  localparam logic [2:0] RC_NONE     = 3'd0;
  localparam logic [2:0] RC_PERIOD   = 3'd1;
  localparam logic [2:0] RC_FULL     = 3'd2;
  localparam logic [2:0] RC_MISSING  = 3'd3;
  localparam logic [2:0] RC_DUP      = 3'd4;
  localparam logic [2:0] RC_NOTFOUND = 3'd5;

  // event counter slots; the status word after the last one is the entry count
  localparam int CTR_SWEEPS    = 0;
  localparam int CTR_WARMUPS   = 1;
  localparam int CTR_STARTUPS  = 2;
  localparam int CTR_ASKED     = 3;
  localparam int CTR_REPORTS   = 4;
  localparam int CTR_UNHEALTHY = 5;
  localparam int NUM_CTRS      = 6;
  localparam int STATUS_WORDS  = 7;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] entry_key;
    logic [15:0] machine_id;
    logic [7:0]  action_code;
    logic [15:0] sweep_count;
    logic [15:0] requester;
    logic [31:0] request_tag;
    logic        check_ok;
    logic        authentic;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [2:0]  refuse_code;
    logic [15:0] out_key;
    logic [15:0] out_machine;
    logic [7:0]  out_action;
    logic        out_ok;
    logic [15:0] out_subscriber;
    logic [31:0] out_tag;
    logic [31:0] out_value;
    logic [2:0]  status_index;
    logic        last;
  } out_beat_t;

  // one table entry
  typedef struct packed {
    logic        used;
    logic [15:0] key;
    logic [15:0] machine;
    logic [7:0]  action;
    logic [15:0] subscriber;
    logic [31:0] tag;
    logic        repeating;
    logic [15:0] period;
    logic [15:0] remaining;
    logic [31:0] runs;
    logic        pending;
  } slot_t;

  // per-cycle command to every cell
  typedef struct packed {
    logic        rotate;   // pass entry to the next cell
    logic        pack;     // cells at or below the top hole move up by one
  } cell_cmd_t;

endpackage

### rtl/pcst_cell.sv
module pcst_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  pcst_pkg::cell_cmd_t cmd,
  input  pcst_pkg::slot_t     prev_in,
  input  logic                hole_above,
  input  logic                load,
  input  pcst_pkg::slot_t     load_slot,
  output logic                hole_out,
  output pcst_pkg::slot_t     slot_out
);
  import pcst_pkg::*;

  slot_t slot_r;
  slot_t slot_nxt;

  assign slot_out = slot_r;
  // a free cell here or anywhere toward the tail
  assign hole_out = hole_above || !slot_r.used;

  always_comb begin
    slot_nxt = slot_r;
    if (load) begin
      slot_nxt = load_slot;
    end else if (cmd.rotate || (cmd.pack && hole_out)) begin
      slot_nxt = prev_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

### rtl/periodic_check_schedule_table_unit.sv
// sequence: a beat is taken in an idle cycle, walks all DEPTH cells, then passes one
// finish and one closing step; a status request emits its words, then closes
// an ignored result is taken in the idle state and starts no walk
// throughput: one beat at a time; a result leaves when the next one is found or at
// closing, after it has been held; a result-side stall freezes the walk
// reset: synchronous active-low rst_n clears counters, entry count, cells and control
module periodic_check_schedule_table_unit #(
  parameter int DEPTH = pcst_pkg::DepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcst_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pcst_pkg::out_beat_t out_data
);
  import pcst_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > 3) ? CW : 3;   // walk position, also the status word index
  localparam int RW = $clog2(MaxResults + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_FIN   = 3'd2;
  localparam logic [2:0] S_STAT  = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  in_beat_t      req_r, req_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;       // walk position
  logic [CW-1:0] count_r, count_nxt;   // entries in table
  logic [RW-1:0] nres_r, nres_nxt;     // results emitted this beat
  logic          found_r, found_nxt;
  logic          rm_r, rm_nxt;         // an entry was dropped during the walk
  logic          hold_r, hold_nxt;     // a result is held to learn whether it is last
  out_beat_t     held_r, held_nxt;
  logic [31:0]   ctr_r [NUM_CTRS];
  logic [31:0]   ctr_nxt [NUM_CTRS];
  logic          ov_r, ov_nxt;
  out_beat_t     od_r, od_nxt;

  // ring of cells; the tail (last cell) holds the oldest entry and the
  // entries sit contiguously from the tail toward cell 0
  cell_cmd_t        cmd;
  slot_t            cells [DEPTH];
  logic [DEPTH-1:0] holes;
  slot_t            head_in;
  slot_t            tail;
  slot_t            new_slot;

  logic out_free;
  logic is_add;
  logic do_add;

  // emit: new result pushes held one out
  logic      emit;
  out_beat_t emit_beat;

  assign tail     = cells[DEPTH-1];
  assign out_free = !ov_r || out_ready;
  assign is_add   = (req_r.req_type == REQ_ADD_REP) || (req_r.req_type == REQ_ADD_ONE);

  // add: the new entry goes into the first free cell after the used ones
  assign do_add = (state_r == S_FIN) && out_free && is_add &&
                  req_r.sweep_count != 16'd0 && count_r < CW'(DEPTH) &&
                  req_r.entry_key != 16'd0 && req_r.machine_id != 16'd0 && !found_r;

  always_comb begin
    new_slot            = '0;
    new_slot.used       = 1'b1;
    new_slot.key        = req_r.entry_key;
    new_slot.machine    = req_r.machine_id;
    new_slot.repeating  = (req_r.req_type == REQ_ADD_REP);
    new_slot.action     = new_slot.repeating ? 8'd0 : req_r.action_code;
    new_slot.subscriber = req_r.requester;
    new_slot.tag        = req_r.request_tag;
    new_slot.period     = new_slot.repeating ? req_r.sweep_count : 16'd0;
    new_slot.remaining  = req_r.sweep_count;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pcst_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .prev_in   ((g == 0) ? head_in : cells[(g == 0) ? 0 : g-1]),
      .hole_above((g == DEPTH - 1) ? 1'b0 : holes[(g == DEPTH - 1) ? g : g+1]),
      .load      (do_add && (count_r == CW'(DEPTH - 1 - g))),
      .load_slot (new_slot),
      .hole_out  (holes[g]),
      .slot_out  (cells[g])
    );
  end

  assign in_ready  = (state_r == S_IDLE) && !hold_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    slot_t e;
    logic  valid_pos;
    logic  was_pending;
    state_nxt = state_r;
    req_nxt   = req_r;
    cnt_nxt   = cnt_r;
    count_nxt = count_r;
    nres_nxt  = nres_r;
    found_nxt = found_r;
    rm_nxt    = rm_r;
    hold_nxt  = hold_r;
    held_nxt  = held_r;
    for (int k = 0; k < NUM_CTRS; k++) ctr_nxt[k] = ctr_r[k];
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    cmd       = '0;
    head_in   = '0;
    emit      = 1'b0;
    emit_beat = '0;
    e         = tail;
    valid_pos = 1'b0;
    was_pending = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !hold_r) begin
          req_nxt   = in_data;
          cnt_nxt   = '0;
          nres_nxt  = '0;
          found_nxt = 1'b0;
          rm_nxt    = 1'b0;
          unique case (in_data.req_type)
            REQ_TICK:   ctr_nxt[CTR_SWEEPS] = ctr_r[CTR_SWEEPS] + 32'd1;
            REQ_WARMUP: ctr_nxt[CTR_WARMUPS] = ctr_r[CTR_WARMUPS] + 32'd1;
            REQ_ACTIV:  ctr_nxt[CTR_STARTUPS] = ctr_r[CTR_STARTUPS] + 32'd1;
            REQ_RESULT: if (in_data.authentic) begin
              ctr_nxt[CTR_REPORTS] = ctr_r[CTR_REPORTS] + 32'd1;
              if (!in_data.check_ok)
                ctr_nxt[CTR_UNHEALTHY] = ctr_r[CTR_UNHEALTHY] + 32'd1;
            end
            default: ;
          endcase
          state_nxt = (in_data.req_type == REQ_STATUS) ? S_STAT : S_WALK;
          if (in_data.req_type == REQ_RESULT && !in_data.authentic) state_nxt = S_IDLE;
        end
      end

      // one entry per cycle rotates through the tail back to the head while the result side
      // does not stall; after DEPTH steps every entry is back in its own cell
      S_WALK: begin
        if (out_free) begin
          cmd.rotate = 1'b1;
          valid_pos  = (cnt_r < KW'(count_r));
          if (valid_pos) begin
            unique case (req_r.req_type)
              REQ_ADD_REP, REQ_ADD_ONE: begin
                if (e.key == req_r.entry_key) found_nxt = 1'b1;
              end
              REQ_CANCEL: begin
                if (!found_r && e.key == req_r.entry_key) begin
                  found_nxt = 1'b1;
                  rm_nxt    = 1'b1;
                  e.used    = 1'b0;
                end
              end
              REQ_TICK: begin
                if (!e.pending) begin
                  if (e.remaining != 16'd0) e.remaining = e.remaining - 16'd1;
                  if (e.remaining == 16'd0) was_pending = 1'b1;
                end
              end
              REQ_WARMUP, REQ_ACTIV: begin
                if (!e.pending) was_pending = 1'b1;
              end
              REQ_RESULT: begin
                if (!found_r && e.key == req_r.entry_key) begin
                  found_nxt = 1'b1;
                  e.runs    = e.runs + 32'd1;
                  e.pending = 1'b0;
                  if (e.subscriber != 16'd0) begin
                    emit = 1'b1;
                    emit_beat.out_kind       = KIND_REPORT;
                    emit_beat.out_key        = req_r.entry_key;
                    emit_beat.out_machine    = req_r.machine_id;
                    emit_beat.out_ok         = req_r.check_ok;
                    emit_beat.out_subscriber = e.subscriber;
                    emit_beat.out_tag        = e.tag;
                    emit_beat.out_value      = e.runs;
                  end
                  if (e.repeating) begin
                    e.remaining = e.period;
                  end else begin
                    e.used = 1'b0;
                    rm_nxt = 1'b1;
                  end
                end
              end
              default: ;
            endcase
            if (was_pending) begin
              e.pending  = 1'b1;
              ctr_nxt[CTR_ASKED] = ctr_r[CTR_ASKED] + 32'd1;
              emit = 1'b1;
              emit_beat.out_kind   = KIND_CHECK;
              emit_beat.out_key    = e.key;
              emit_beat.out_machine = e.machine;
              emit_beat.out_action = e.action;
            end
          end
          // a removed entry travels on as a free cell and is closed up at finish
          head_in = e;
          cnt_nxt = cnt_r + KW'(1);
          if (cnt_r == KW'(DEPTH - 1)) state_nxt = S_FIN;
        end
      end

      // one packing step closes the hole of a removed entry; add/cancel answer
      S_FIN: begin
        if (out_free) begin
          cmd.pack = rm_r;
          if (do_add) count_nxt = count_r + CW'(1);
          else if (rm_r) count_nxt = count_r - CW'(1);
          unique case (req_r.req_type)
            REQ_ADD_REP, REQ_ADD_ONE: begin
              emit = 1'b1;
              emit_beat.out_kind = KIND_REFUSE;
              if (req_r.sweep_count == 16'd0) emit_beat.refuse_code = RC_PERIOD;
              else if (count_r >= CW'(DEPTH)) emit_beat.refuse_code = RC_FULL;
              else if (req_r.entry_key == 16'd0 || req_r.machine_id == 16'd0)
                emit_beat.refuse_code = RC_MISSING;
              else if (found_r) emit_beat.refuse_code = RC_DUP;
              else begin
                emit_beat.out_kind    = KIND_ACK;
                emit_beat.refuse_code = RC_NONE;
              end
            end
            REQ_CANCEL: begin
              emit = 1'b1;
              emit_beat.out_kind    = found_r ? KIND_ACK : KIND_REFUSE;
              emit_beat.refuse_code = found_r ? RC_NONE : RC_NOTFOUND;
            end
            default: ;
          endcase
          state_nxt = S_LAST;
        end
      end

      S_STAT: begin
        if (out_free) begin
          emit = 1'b1;
          emit_beat.out_kind     = KIND_STATUS;
          emit_beat.status_index = cnt_r[2:0];
          emit_beat.out_value    = (cnt_r < KW'(NUM_CTRS)) ? ctr_r[cnt_r[2:0]] :
                                   32'(count_r);
          cnt_nxt = cnt_r + KW'(1);
          if (cnt_r == KW'(STATUS_WORDS - 1)) state_nxt = S_LAST;
        end
      end

      // closing: the held result goes out marked last
      default: begin
        if (out_free) begin
          if (hold_r) begin
            ov_nxt      = 1'b1;
            od_nxt      = held_r;
            od_nxt.last = 1'b1;
            hold_nxt    = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
    endcase

    // results beyond the per-beat limit are dropped
    if (emit) begin
      if (nres_r < RW'(MaxResults)) begin
        nres_nxt = nres_r + RW'(1);
        if (hold_r) begin
          ov_nxt = 1'b1;
          od_nxt = held_r;
        end
        hold_nxt = 1'b1;
        held_nxt = emit_beat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      hold_r  <= 1'b0;
      ov_r    <= 1'b0;
      for (int k = 0; k < NUM_CTRS; k++) ctr_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      hold_r  <= hold_nxt;
      ov_r    <= ov_nxt;
      for (int k = 0; k < NUM_CTRS; k++) ctr_r[k] <= ctr_nxt[k];
    end
    req_r   <= req_nxt;
    cnt_r   <= cnt_nxt;
    nres_r  <= nres_nxt;
    found_r <= found_nxt;
    rm_r    <= rm_nxt;
    held_r  <= held_nxt;
    od_r    <= od_nxt;
  end

endmodule

### tb/sv/periodic_check_schedule_table_unit_tb.sv
module periodic_check_schedule_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcst_pkg::*;

  localparam int Depth = 16;

  // one schedule entry as the predictor keeps it
  typedef struct {
    logic [15:0] key;
    logic [15:0] machine;
    logic [7:0]  action;
    logic [15:0] subscriber;
    logic [31:0] tag;
    bit          repeating;
    logic [15:0] period;
    logic [15:0] remaining;
    logic [31:0] runs;
    bit          pending;
  } sched_entry_t;

  int mismatch_count = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // predicts the beats each request causes and checks the result stream
  class schedule_scoreboard;
    sched_entry_t entries[$];
    logic [31:0]  counters[NUM_CTRS];
    out_beat_t    pending_beats[$];
    out_beat_t    beat_buf[$];

    function new();
      foreach (counters[i]) counters[i] = '0;
    endfunction

    function void add_beat(out_beat_t b);
      if (beat_buf.size() < MaxResults) beat_buf = {beat_buf, b};
    endfunction

    function void answer(logic [2:0] kind, logic [2:0] code);
      out_beat_t b;
      b = '0;
      b.out_kind = kind;
      b.refuse_code = code;
      add_beat(b);
    endfunction

    function int find_key(logic [15:0] key);
      foreach (entries[i]) if (entries[i].key == key) return i;
      return -1;
    endfunction

    function void ask_entry(int i);
      out_beat_t b;
      if (entries[i].pending) return;
      entries[i].pending = 1;
      counters[CTR_ASKED]++;
      b = '0;
      b.out_kind = KIND_CHECK;
      b.out_key = entries[i].key;
      b.out_machine = entries[i].machine;
      b.out_action = entries[i].action;
      add_beat(b);
    endfunction

    function void note_request(in_beat_t r);
      sched_entry_t e;
      out_beat_t    b;
      int           idx;
      beat_buf.delete();
      case (r.req_type)
        REQ_ADD_REP, REQ_ADD_ONE: begin
          if (r.sweep_count == 0) answer(KIND_REFUSE, RC_PERIOD);
          else if (entries.size() >= Depth) answer(KIND_REFUSE, RC_FULL);
          else if (r.entry_key == 0 || r.machine_id == 0) answer(KIND_REFUSE, RC_MISSING);
          else if (find_key(r.entry_key) >= 0) answer(KIND_REFUSE, RC_DUP);
          else begin
            e.key = r.entry_key;
            e.machine = r.machine_id;
            e.repeating = (r.req_type == REQ_ADD_REP);
            e.action = e.repeating ? 8'd0 : r.action_code;
            e.subscriber = r.requester;
            e.tag = r.request_tag;
            e.period = e.repeating ? r.sweep_count : 16'd0;
            e.remaining = r.sweep_count;
            e.runs = '0;
            e.pending = 0;
            entries = {entries, e};
            answer(KIND_ACK, RC_NONE);
          end
        end
        REQ_CANCEL: begin
          idx = find_key(r.entry_key);
          if (idx < 0) answer(KIND_REFUSE, RC_NOTFOUND);
          else begin
            entries.delete(idx);
            answer(KIND_ACK, RC_NONE);
          end
        end
        REQ_TICK: begin
          counters[CTR_SWEEPS]++;
          foreach (entries[i]) begin
            if (!entries[i].pending) begin
              if (entries[i].remaining > 0) entries[i].remaining--;
              if (entries[i].remaining == 0) ask_entry(i);
            end
          end
        end
        REQ_RESULT: begin
          if (r.authentic) begin
            counters[CTR_REPORTS]++;
            if (!r.check_ok) counters[CTR_UNHEALTHY]++;
            idx = find_key(r.entry_key);
            if (idx >= 0) begin
              entries[idx].runs++;
              entries[idx].pending = 0;
              if (entries[idx].subscriber != 0) begin
                b = '0;
                b.out_kind = KIND_REPORT;
                b.out_key = r.entry_key;
                b.out_machine = r.machine_id;
                b.out_ok = r.check_ok;
                b.out_subscriber = entries[idx].subscriber;
                b.out_tag = entries[idx].tag;
                b.out_value = entries[idx].runs;
                add_beat(b);
              end
              if (entries[idx].repeating) entries[idx].remaining = entries[idx].period;
              else entries.delete(idx);
            end
          end
        end
        REQ_WARMUP, REQ_ACTIV: begin
          if (r.req_type == REQ_WARMUP) counters[CTR_WARMUPS]++;
          else counters[CTR_STARTUPS]++;
          foreach (entries[i]) ask_entry(i);
        end
        default: begin
          for (int i = 0; i < STATUS_WORDS; i++) begin
            b = '0;
            b.out_kind = KIND_STATUS;
            b.out_value = (i < NUM_CTRS) ? counters[i] : 32'(entries.size());
            b.status_index = 3'(i);
            add_beat(b);
          end
        end
      endcase
      if (beat_buf.size() > 0) beat_buf[beat_buf.size() - 1].last = 1'b1;
      foreach (beat_buf[i]) pending_beats = {pending_beats, beat_buf[i]};
    endfunction

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", got));
        return;
      end
      want = pending_beats.pop_front();
      if (got.out_kind !== want.out_kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.out_kind, want.out_kind));
      if (got.refuse_code !== want.refuse_code)
        report_mismatch($sformatf("refuse %0d, want %0d", got.refuse_code, want.refuse_code));
      if (got.out_key !== want.out_key)
        report_mismatch($sformatf("key %h, want %h", got.out_key, want.out_key));
      if (got.out_machine !== want.out_machine)
        report_mismatch($sformatf("machine %h, want %h", got.out_machine, want.out_machine));
      if (got.out_action !== want.out_action)
        report_mismatch($sformatf("action %h, want %h", got.out_action, want.out_action));
      if (got.out_ok !== want.out_ok)
        report_mismatch($sformatf("ok %b, want %b", got.out_ok, want.out_ok));
      if (got.out_subscriber !== want.out_subscriber)
        report_mismatch($sformatf("subscriber %h, want %h", got.out_subscriber,
                                  want.out_subscriber));
      if (got.out_tag !== want.out_tag)
        report_mismatch($sformatf("tag %h, want %h", got.out_tag, want.out_tag));
      if (got.out_value !== want.out_value)
        report_mismatch($sformatf("value %h, want %h", got.out_value, want.out_value));
      if (got.status_index !== want.status_index)
        report_mismatch($sformatf("status index %0d, want %0d", got.status_index,
                                  want.status_index));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  schedule_scoreboard sb = new();
  bit quiet_phase = 0;   // no idling on either side near the end
  bit drive_done = 0;

  periodic_check_schedule_table_unit #(.DEPTH(Depth)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // keys drawn mostly from a small pool so cancels and results find entries
  logic [15:0] key_pool[$];

  function automatic logic [15:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(0, 9) < 8)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return 16'($urandom_range(1, 40));
  endfunction

  // present one beat and hold it until accepted; random idle burst first
  task automatic send_beat(input in_beat_t b);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(b);
    if (b.req_type inside {REQ_ADD_REP, REQ_ADD_ONE} && b.entry_key != 0)
      key_pool = {key_pool, b.entry_key};
    @(negedge clk);
  endtask

  function automatic in_beat_t make_req(logic [2:0] kind, logic [15:0] key,
                                        logic [15:0] mach, logic [15:0] cnt);
    in_beat_t b;
    b.req_type = kind;
    b.entry_key = key;
    b.machine_id = mach;
    b.action_code = 8'($urandom);
    b.sweep_count = cnt;
    b.requester = 16'($urandom);
    b.request_tag = $urandom;
    b.check_ok = 1'($urandom);
    b.authentic = 1'b1;
    return b;
  endfunction

  // random request, weighted toward meaningful sequences
  task automatic send_random();
    in_beat_t b;
    int sel;
    sel = $urandom_range(0, 99);
    b = make_req(REQ_TICK, pick_key(), 16'($urandom_range(1, 65535)),
                 16'($urandom_range(1, 4)));
    if (sel < 22) b.req_type = REQ_ADD_REP;
    else if (sel < 34) b.req_type = REQ_ADD_ONE;
    else if (sel < 42) b.req_type = REQ_CANCEL;
    else if (sel < 64) b.req_type = REQ_TICK;
    else if (sel < 86) b.req_type = REQ_RESULT;
    else if (sel < 90) b.req_type = REQ_WARMUP;
    else if (sel < 93) b.req_type = REQ_ACTIV;
    else b.req_type = REQ_STATUS;
    // noise: full-range, zero or edge-value fields now and then
    if ($urandom_range(0, 9) == 0) b.entry_key = 16'($urandom);
    if ($urandom_range(0, 14) == 0) b.machine_id = 16'($urandom_range(0, 1));
    if ($urandom_range(0, 14) == 0) b.sweep_count = 16'($urandom);
    if ($urandom_range(0, 19) == 0) b.sweep_count = 16'd0;
    if ($urandom_range(0, 7) == 0) b.requester = 16'd0;
    if ($urandom_range(0, 7) == 0) b.authentic = 1'b0;
    send_beat(b);
  endtask

  // result side: random stall bursts until the quiet phase
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // sample accepted result beats at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_beat(out_data);
  end

  initial begin
    in_beat_t b;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: status from reset, add refusals in priority order
    send_beat(make_req(REQ_STATUS, 16'd0, 16'd0, 16'd0));
    send_beat(make_req(REQ_ADD_REP, 16'd0, 16'd0, 16'd0));        // bad period wins
    send_beat(make_req(REQ_ADD_REP, 16'd0, 16'd5, 16'd3));        // missing key
    send_beat(make_req(REQ_ADD_ONE, 16'd7, 16'd0, 16'd3));        // missing machine
    send_beat(make_req(REQ_ADD_REP, 16'hffff, 16'hffff, 16'hffff));
    send_beat(make_req(REQ_ADD_REP, 16'hffff, 16'd1, 16'd1));     // duplicate
    b = make_req(REQ_ADD_ONE, 16'd1, 16'd2, 16'd1);
    b.action_code = 8'hff;
    b.requester = 16'hffff;
    b.request_tag = 32'hffff_ffff;
    send_beat(b);
    send_beat(make_req(REQ_CANCEL, 16'd999, 16'd0, 16'd0));       // unknown key
    send_beat(make_req(REQ_TICK, 16'd0, 16'd0, 16'd0));           // one-shot fires
    b = make_req(REQ_RESULT, 16'd1, 16'hffff, 16'd0);
    b.authentic = 1'b0;                                           // ignored
    send_beat(b);
    b.authentic = 1'b1;
    b.check_ok = 1'b0;
    send_beat(b);                                                 // report, removal
    b.entry_key = 16'd4242;
    send_beat(b);                                                 // no entry, counted
    send_beat(make_req(REQ_WARMUP, 16'd0, 16'd0, 16'd0));
    send_beat(make_req(REQ_ACTIV, 16'd0, 16'd0, 16'd0));          // nothing to ask
    send_beat(make_req(REQ_CANCEL, 16'hffff, 16'd0, 16'd0));
    // fill the table, then overflow
    for (int i = 0; i < Depth; i++)
      send_beat(make_req(REQ_ADD_REP, 16'(100 + i), 16'(i + 1), 16'(1 + i % 3)));
    send_beat(make_req(REQ_ADD_REP, 16'd500, 16'd1, 16'd1));      // full
    send_beat(make_req(REQ_ACTIV, 16'd0, 16'd0, 16'd0));          // sixteen checks
    send_beat(make_req(REQ_STATUS, 16'd0, 16'd0, 16'd0));
    for (int i = 0; i < Depth; i++)
      send_beat(make_req(REQ_CANCEL, 16'(100 + i), 16'd0, 16'd0));

    // random part; the last stretch runs with no idling
    for (int n = 0; n < 300; n++) begin
      if (n == 260) quiet_phase = 1;
      send_random();
    end
    send_beat(make_req(REQ_STATUS, 16'd0, 16'd0, 16'd0));
    in_valid <= 1'b0;
    drive_done = 1;
  end

  // end of run: drain, then allow for the walk latency
  initial begin
    wait (drive_done);
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (4 * Depth + 20) @(posedge clk);
    if (mismatch_count == 0 && sb.pending_beats.size() == 0)
      $display("periodic_check_schedule_table_unit regression: pass");
    else
      $display("periodic_check_schedule_table_unit regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("periodic_check_schedule_table_unit regression: fail");
    $finish;
  end
endmodule

### periodic_check_schedule_table_unit.f
rtl/pcst_pkg.sv
rtl/pcst_cell.sv
rtl/periodic_check_schedule_table_unit.sv
tb/sv/periodic_check_schedule_table_unit_tb.sv
